>>> src/psh_pkg.sv
// ----------------------------------------------------------------------------
// psh_pkg: path split hasher package
// Shared constants, types and CRC/case-fold functions.
// ----------------------------------------------------------------------------
package psh_pkg;

	localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [7:0]  SLASH_BYTE = 8'h2F;
	localparam logic [7:0]  CASE_DELTA = 8'h20;

	typedef struct packed {
		logic       valid;
		logic [7:0] path_byte;
		logic       is_last;
	} psh_item_t;

	function automatic logic [7:0] fold_case(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b inside {[8'h41:8'h5A]}) begin
			r = b + CASE_DELTA;
		end
		return r;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> src/psh_path_if.sv
// ----------------------------------------------------------------------------
// psh_path_if: path byte channel
// Valid/ready channel carrying one path byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface psh_path_if;
	logic       valid;
	logic       ready;
	logic [7:0] path_byte;
	logic       is_last;

	modport source (output valid, output path_byte, output is_last, input ready);
	modport sink (input valid, input path_byte, input is_last, output ready);
endinterface

>>> src/psh_hash_if.sv
// ----------------------------------------------------------------------------
// psh_hash_if: hash result channel
// Valid/ready channel carrying the directory and name hashes of one path.
// ----------------------------------------------------------------------------
interface psh_hash_if;
	logic        valid;
	logic        ready;
	logic [31:0] dir_crc;
	logic [31:0] name_hash;
	logic        no_slash_error;

	modport source (output valid, output dir_crc, output name_hash, output no_slash_error,
		input ready);
	modport sink (input valid, input dir_crc, input name_hash, input no_slash_error,
		output ready);
endinterface

>>> src/psh_in_stage.sv
// ----------------------------------------------------------------------------
// psh_in_stage: input register
// Registers one path byte transaction and hands it to the hash core.
// ----------------------------------------------------------------------------
module psh_in_stage
	import psh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	psh_path_if.sink   path,
	input  logic       take,
	output psh_item_t  item
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	assign path.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (path.ready) begin
			valid_s1 <= path.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (path.ready && path.valid) begin
			byte_s1 <= path.path_byte;
			last_s1 <= path.is_last;
		end
	end

	assign item = '{valid: valid_s1, path_byte: byte_s1, is_last: last_s1};

endmodule

>>> src/psh_hash_core.sv
// ----------------------------------------------------------------------------
// psh_hash_core: CRC state and result register
// Folds case, updates the whole and tail CRCs, and registers the result.
// ----------------------------------------------------------------------------
module psh_hash_core
	import psh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  psh_item_t  item,
	output logic       take,
	psh_hash_if.source hash
);

	logic [31:0] whole_q;
	logic [31:0] tail_q;
	logic [31:0] saved_q;
	logic        seen_q;
	logic        out_valid_q;
	logic [31:0] dir_q;
	logic [31:0] name_q;
	logic        err_q;

	logic [7:0]  b;
	logic        is_slash;
	logic [31:0] whole_next;
	logic [31:0] tail_next;
	logic [31:0] saved_next;
	logic        seen_next;
	logic        slot_free;

	always_comb begin
		b          = fold_case(item.path_byte);
		is_slash   = (b == SLASH_BYTE);
		whole_next = crc_byte(whole_q, b);
		tail_next  = is_slash ? CRC_PRESET : crc_byte(tail_q, b);
		saved_next = is_slash ? whole_q : saved_q;
		seen_next  = is_slash || seen_q;
	end

	assign slot_free = !out_valid_q || hash.ready;
	assign take      = item.valid && (!item.is_last || slot_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q <= CRC_PRESET;
			tail_q  <= CRC_PRESET;
			saved_q <= '0;
			seen_q  <= 1'b0;
		end else if (take) begin
			if (item.is_last) begin
				whole_q <= CRC_PRESET;
				tail_q  <= CRC_PRESET;
				saved_q <= '0;
				seen_q  <= 1'b0;
			end else begin
				whole_q <= whole_next;
				tail_q  <= tail_next;
				saved_q <= saved_next;
				seen_q  <= seen_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && item.is_last) begin
			out_valid_q <= 1'b1;
		end else if (hash.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.is_last) begin
			dir_q  <= seen_next ? saved_next : '0;
			name_q <= seen_next ? tail_next : '0;
			err_q  <= !seen_next;
		end
	end

	assign hash.valid          = out_valid_q;
	assign hash.dir_crc        = dir_q;
	assign hash.name_hash      = name_q;
	assign hash.no_slash_error = err_q;

endmodule

>>> src/path_split_crc32_hasher.sv
// ----------------------------------------------------------------------------
// path_split_crc32_hasher: path directory/name CRC-32 hasher
// Top level: input register, CRC core with result register, assertions.
// ----------------------------------------------------------------------------
// Takes one path byte per clock, folds A-Z to lower case and keeps reflected
// CRC-32 values (preset all ones, no final XOR) over the whole path and over
// the bytes since the last slash. The byte marked last yields one result
// after it passes the input register and the result register: the hash of
// everything before the last slash and the hash of the name after it, or an
// error flag with zero hashes when the path holds no slash. Throughput is one
// byte per cycle, set by the byte-wide CRC update between the input register
// and the state registers; the input stalls only while a last byte waits for
// a result register that the consumer has not yet emptied.
module path_split_crc32_hasher
	import psh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	psh_path_if.sink   path,
	psh_hash_if.source hash
);

	psh_item_t item_s1;
	logic      take;

	psh_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.path   (path),
		.take   (take),
		.item   (item_s1)
	);

	psh_hash_core u_hash_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.take   (take),
		.hash   (hash)
	);

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hash.valid) |-> $past(item_s1.valid && item_s1.is_last))
		else $error("result appeared without a last byte");

	a_error_zero_hashes: assert property (@(posedge clk) disable iff (!arst_n)
		(hash.valid && hash.no_slash_error) |-> (hash.dir_crc == '0 && hash.name_hash == '0))
		else $error("error result carries nonzero hashes");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!path.ready |-> (item_s1.valid && item_s1.is_last && hash.valid && !hash.ready))
		else $error("input stalled without a blocked last byte");

	a_take_frees_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item_s1.is_last) |=> hash.valid)
		else $error("last byte taken but no result registered");

endmodule
